/* rtl/core/dmt_pkg.sv */
package dmt_pkg;

  localparam int CH_W = 2;
  localparam int SMP_W = 16;
  localparam int RNG_W = 17;
  localparam int HOLD_W = 16;
  localparam int CNT_W = 32;
  localparam int TUNE_W = 24;
  localparam int WIN_W = 16;
  localparam int PCT_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TUNING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERCENTILE = 2'd3;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_UP = 2'd1;
  localparam logic [1:0] EV_DOWN = 2'd2;

  localparam logic signed [SMP_W:0] WIN_MIN_INIT = 17'sd10000;
  localparam logic signed [SMP_W:0] WIN_MAX_INIT = -17'sd10000;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic signed [SMP_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_channel;
    logic signed [SMP_W-1:0] level;
    logic [1:0] event_res;
    logic in_tuning;
    logic [CNT_W-1:0] sample_index;
  } out_item_t;

  typedef struct packed {
    logic [HOLD_W-1:0] refractory;
    logic [TUNE_W-1:0] tuning;
    logic [WIN_W-1:0] window;
    logic [PCT_W-1:0] percentile;
  } cfg_t;

endpackage

/* rtl/core/dmt_if.sv */
interface dmt_in_if;
  logic valid;
  logic ready;
  logic [dmt_pkg::CH_W-1:0] channel;
  logic signed [dmt_pkg::SMP_W-1:0] sample;
  modport source(output valid, channel, sample, input ready);
  modport sink(input valid, channel, sample, output ready);
endinterface

interface dmt_out_if;
  logic valid;
  logic ready;
  logic [dmt_pkg::CH_W-1:0] out_channel;
  logic signed [dmt_pkg::SMP_W-1:0] level;
  logic [1:0] event_res;
  logic in_tuning;
  logic [dmt_pkg::CNT_W-1:0] sample_index;
  modport source(output valid, out_channel, level, event_res, in_tuning, sample_index,
                 input ready);
  modport sink(input valid, out_channel, level, event_res, in_tuning, sample_index,
               output ready);
endinterface

/* rtl/core/dmt_fifo.sv */
module dmt_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  dmt_pkg::in_item_t    wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output dmt_pkg::in_item_t    rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  dmt_pkg::in_item_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign wr_ready = (cnt != (AW+1)'(DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (rd_valid && rd_ready) begin
        rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(wr_valid && wr_ready) - (AW+1)'(rd_valid && rd_ready);
    end
    if (wr_valid && wr_ready) begin
      mem[wp] <= wr_data;
    end
  end
endmodule

/* rtl/core/dmt_back.sv */
module dmt_back #(
  parameter int CHANNELS = 4,
  parameter int MAX_WINDOWS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  dmt_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  dmt_pkg::in_item_t  in_data,
  dmt_out_if.source          res
);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WW = $clog2(MAX_WINDOWS);
  localparam int FW = WW + 1;
  localparam int MW = CW + WW;
  localparam int SW = dmt_pkg::SMP_W;
  localparam int RW = dmt_pkg::RNG_W;
  localparam int WIN_CNT_W = dmt_pkg::WIN_W;
  localparam int CNT_W = dmt_pkg::CNT_W;
  localparam int CB = $clog2(CNT_W);
  // ceil(2^32 / 100): exact floor(x / 100) for x below 2^30
  localparam logic [25:0] DIV100_M = 26'd42949673;

  typedef enum logic [2:0] {
    S_RUN, S_KSET, S_OUTER, S_INNER, S_LAST, S_OUT, S_REMOD
  } state_t;
  state_t state;

  logic signed [SW-1:0] level_store [CHANNELS];
  logic signed [RW-1:0] step_size [CHANNELS];
  logic [dmt_pkg::HOLD_W-1:0] hold_count [CHANNELS];
  logic [CNT_W-1:0] sample_count [CHANNELS];
  logic tuning_flag [CHANNELS];
  logic signed [SW:0] window_min [CHANNELS];
  logic signed [SW:0] window_max [CHANNELS];
  logic [FW-1:0] range_fill [CHANNELS];
  logic [WIN_CNT_W-1:0] win_pos [CHANNELS];

  logic signed [RW-1:0] range_mem [CHANNELS*(2**WW)];
  logic signed [RW-1:0] rd_data;
  logic [MW-1:0] rd_addr;

  logic [FW-1:0] n, k, i, j, gt, eq;
  logic signed [RW-1:0] cand;
  logic [FW+6:0] prod;
  logic [FW+32:0] kq_full;
  logic [FW-1:0] kq;
  logic [dmt_pkg::PCT_W-1:0] pct;

  // window position rebuild after a window length change
  logic [CW-1:0] rm_ch;
  logic [CB-1:0] rm_bit;
  logic [WIN_CNT_W-1:0] rm_rem, rm_wlen, rm_next, wlen_seen;
  logic [WIN_CNT_W:0] rm_sh;

  dmt_pkg::out_item_t ob;
  logic ob_valid;

  logic [CW-1:0] c;
  logic in_range;
  logic signed [SW-1:0] s;
  logic start_tune_end;
  logic [WIN_CNT_W-1:0] wlen;
  logic acc;

  assign s = in_data.sample;
  assign in_range = (32'(in_data.channel) < 32'(CHANNELS));
  assign c = CW'(in_data.channel);
  assign wlen = (cfg.window == '0) ? WIN_CNT_W'(1) : cfg.window;
  assign start_tune_end = in_range && tuning_flag[c] &&
                          (sample_count[c] >= CNT_W'(cfg.tuning));
  assign in_ready = (state == S_RUN) && (wlen == wlen_seen) &&
                    (!ob_valid || res.ready) && !start_tune_end;
  assign acc = in_valid && in_ready;

  assign res.valid = ob_valid;
  assign res.out_channel = ob.out_channel;
  assign res.level = ob.level;
  assign res.event_res = ob.event_res;
  assign res.in_tuning = ob.in_tuning;
  assign res.sample_index = ob.sample_index;

  always_comb begin
    case (state)
      S_OUTER: rd_addr = {c, WW'(0)};
      S_INNER: rd_addr = {c, WW'(j + 1'b1)};
      default: rd_addr = {c, i[WW-1:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= range_mem[rd_addr];
  end

  always_comb begin
    pct = (cfg.percentile > 7'd100) ? 7'd100 : cfg.percentile;
    kq_full = (FW+33)'(prod) * (FW+33)'(DIV100_M);
    kq = kq_full[FW+31:32];
  end

  always_comb begin
    rm_sh = {rm_rem, sample_count[rm_ch][rm_bit]};
    rm_next = (rm_sh >= {1'b0, rm_wlen}) ? WIN_CNT_W'(rm_sh - {1'b0, rm_wlen}) :
              rm_sh[WIN_CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    logic signed [SW+1:0] up, dn, lv;
    logic tf;
    logic [FW-1:0] rf;
    logic [dmt_pkg::HOLD_W-1:0] hc;
    logic [1:0] ev;
    logic signed [SW:0] wmn, wmx;
    dmt_pkg::out_item_t o;
    if (rst) begin
      state <= S_RUN;
      ob_valid <= 1'b0;
      wlen_seen <= WIN_CNT_W'(10);
      rm_ch <= '0;
      rm_bit <= '0;
      rm_rem <= '0;
      rm_wlen <= WIN_CNT_W'(10);
      for (int q = 0; q < CHANNELS; q++) begin
        level_store[q] <= '0;
        step_size[q] <= '0;
        hold_count[q] <= 16'd1;
        sample_count[q] <= '0;
        tuning_flag[q] <= 1'b1;
        window_min[q] <= dmt_pkg::WIN_MIN_INIT;
        window_max[q] <= dmt_pkg::WIN_MAX_INIT;
        range_fill[q] <= '0;
        win_pos[q] <= '0;
      end
    end else begin
      if (res.ready && !acc) ob_valid <= 1'b0;
      case (state)
        S_RUN: begin
          if (wlen != wlen_seen) begin
            rm_wlen <= wlen;
            rm_ch <= '0;
            rm_bit <= CB'(CNT_W-1);
            rm_rem <= '0;
            state <= S_REMOD;
          end else if (in_valid && start_tune_end && (!ob_valid || res.ready)) begin
            n <= range_fill[c];
            prod <= (FW+7)'(range_fill[c]) * (FW+7)'(7'd100 - pct);
            state <= S_KSET;
          end else if (acc) begin
            o.out_channel = in_data.channel;
            o.level = '0;
            o.event_res = dmt_pkg::EV_NONE;
            o.in_tuning = 1'b0;
            o.sample_index = '0;
            if (in_range) begin
              tf = tuning_flag[c];
              rf = range_fill[c];
              hc = hold_count[c];
              ev = dmt_pkg::EV_NONE;
              if (sample_count[c] < CNT_W'(cfg.tuning)) begin
                wmn = window_min[c];
                wmx = window_max[c];
                if ((SW+1)'(s) < wmn) wmn = (SW+1)'(s);
                if ((SW+1)'(s) > wmx) wmx = (SW+1)'(s);
                if (win_pos[c] == '0) begin
                  if (rf < FW'(MAX_WINDOWS)) begin
                    range_mem[{c, rf[WW-1:0]}] <= RW'(wmx - wmn);
                    rf = rf + 1'b1;
                  end
                  wmx = dmt_pkg::WIN_MAX_INIT;
                  wmn = dmt_pkg::WIN_MIN_INIT;
                end
                window_min[c] <= wmn;
                window_max[c] <= wmx;
              end
              // win_pos tracks sample_count modulo the window length
              if (sample_count[c] == '1) begin
                win_pos[c] <= '0;
              end else begin
                win_pos[c] <= (win_pos[c] + 1'b1 >= wlen) ? '0 : win_pos[c] + 1'b1;
              end
              sample_count[c] <= sample_count[c] + 1'b1;
              lv = (SW+2)'(level_store[c]);
              if (!tf) begin
                up = lv + (SW+2)'(step_size[c]);
                dn = lv - (SW+2)'(step_size[c]);
                rf = '0;
                if (hc >= cfg.refractory) begin
                  if ((SW+2)'(s) > up) begin
                    ev = dmt_pkg::EV_UP; hc = '0; lv = up;
                  end else if ((SW+2)'(s) < dn) begin
                    ev = dmt_pkg::EV_DOWN; hc = '0; lv = dn;
                  end
                end
                if (lv > (SW+2)'(32767)) lv = (SW+2)'(32767);
                if (lv < -(SW+2)'(32768)) lv = -(SW+2)'(32768);
                if (hc != '1) hc = hc + 1'b1;
                hold_count[c] <= hc;
                level_store[c] <= SW'(lv);
                o.level = SW'(lv);
              end
              range_fill[c] <= rf;
              o.event_res = ev;
              o.in_tuning = tf;
              o.sample_index = sample_count[c] + 1'b1;
            end
            ob_valid <= 1'b1;
            ob <= o;
          end
        end
        S_REMOD: begin
          if (rm_bit == '0) begin
            win_pos[rm_ch] <= rm_next;
            rm_rem <= '0;
            rm_bit <= CB'(CNT_W-1);
            if (32'(rm_ch) == CHANNELS - 1) begin
              wlen_seen <= rm_wlen;
              state <= S_RUN;
            end else begin
              rm_ch <= rm_ch + 1'b1;
            end
          end else begin
            rm_rem <= rm_next;
            rm_bit <= rm_bit - 1'b1;
          end
        end
        S_KSET: begin
          if (n == '0) begin
            step_size[c] <= '0;
            level_store[c] <= '0;
            tuning_flag[c] <= 1'b0;
            state <= S_RUN;
          end else begin
            k <= (kq >= n) ? n - 1'b1 : kq;
            i <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          state <= S_OUTER;
        end
        S_OUTER: begin
          cand <= rd_data;
          j <= '0;
          gt <= '0;
          eq <= '0;
          state <= S_INNER;
        end
        S_INNER: begin
          if (rd_data > cand) gt <= gt + 1'b1;
          else if (rd_data == cand) eq <= eq + 1'b1;
          if (j + 1'b1 == n) begin
            state <= S_LAST;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_LAST: begin
          if (gt <= k && k < gt + eq) begin
            step_size[c] <= cand;
            level_store[c] <= '0;
            tuning_flag[c] <= 1'b0;
            state <= S_RUN;
          end else if (i + 1'b1 == n) begin
            step_size[c] <= '0;
            level_store[c] <= '0;
            tuning_flag[c] <= 1'b0;
            state <= S_RUN;
          end else begin
            i <= i + 1'b1;
            state <= S_OUT;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end
endmodule

/* rtl/core/delta_modulator_with_tuning.sv */
// Per-channel delta modulator with self-tuning step. One result per accepted beat;
// a beat is held while the result output is stalled. The first beat of a channel
// after its tuning length is held while the step is selected from that channel's
// stored window ranges by a count-and-compare pass over the range memory. A change
// of the window length stalls the input while each channel's window position is
// rebuilt from its sample count. A two-entry queue parts the input port from the
// execution unit.
module delta_modulator_with_tuning #(
  parameter int CHANNELS = 4,
  parameter int MAX_WINDOWS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmt_pkg::CFG_DATA_W-1:0]    cfg_data,
  dmt_in_if.sink                            in_ch,
  dmt_out_if.source                         out_ch
);
  dmt_pkg::cfg_t cfg;
  dmt_pkg::in_item_t qin, qout;
  logic q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.refractory <= 16'd1;
      cfg.tuning <= 24'd10000;
      cfg.window <= 16'd10;
      cfg.percentile <= 7'd40;
    end else if (cfg_we) begin
      case (cfg_index)
        dmt_pkg::REG_REFRACTORY: cfg.refractory <= cfg_data[15:0];
        dmt_pkg::REG_TUNING: cfg.tuning <= cfg_data;
        dmt_pkg::REG_WINDOW: cfg.window <= cfg_data[15:0];
        dmt_pkg::REG_PERCENTILE: cfg.percentile <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign qin.channel = in_ch.channel;
  assign qin.sample = in_ch.sample;

  dmt_fifo #(.DEPTH(2)) u_fifo (
    .clk(clk), .rst(rst),
    .wr_valid(in_ch.valid), .wr_ready(in_ch.ready), .wr_data(qin),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(qout)
  );

  dmt_back #(.CHANNELS(CHANNELS), .MAX_WINDOWS(MAX_WINDOWS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(q_valid), .in_ready(q_ready), .in_data(qout),
    .res(out_ch)
  );
endmodule

/* rtl/core/dmt_checker.sv */
module dmt_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] event_res,
  input logic in_tuning,
  input logic [15:0] level
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_ev: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_res != 2'd3) else $error("bad event code");
  a_tune: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_tuning |-> event_res == 2'd0 && level == 16'd0)
    else $error("event during tuning");
endmodule

bind delta_modulator_with_tuning dmt_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .event_res(out_ch.event_res), .in_tuning(out_ch.in_tuning), .level(out_ch.level)
);
